/* rtl/tbpf_pkg.sv */
// Package for the tiled background pixel fetch block.
// Holds request and result types, kind codes, mode codes and sizes.
`default_nettype none
package tbpf_pkg;
  localparam int unsigned VideoHalfwords = 49152;
  localparam int unsigned PaletteEntries = 512;
  localparam int unsigned PaddrW = 9;

  localparam logic [1:0] KindVram   = 2'd0;
  localparam logic [1:0] KindPal    = 2'd1;
  localparam logic [1:0] KindQuery  = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  localparam logic [2:0] ModeNone   = 3'd0;
  localparam logic [2:0] ModeText   = 3'd1;
  localparam logic [2:0] ModeAffine = 3'd2;
  localparam logic [2:0] ModeBmp16  = 3'd3;
  localparam logic [2:0] ModeBmp8   = 3'd4;
  localparam logic [2:0] ModeBmpSm  = 3'd5;

  localparam logic [1:0] RegControl = 2'd0;
  localparam logic [1:0] RegMode    = 2'd1;
  localparam logic [1:0] RegPage    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] mem_address;
    logic [15:0] write_value;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       opaque;
  } res_t;

  // Queue entry between front and back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] mem_address;
    logic [15:0] write_value;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
  } job_t;
endpackage
`default_nettype wire

/* rtl/tbpf_front.sv */
// Front part: accepts requests and queues them for the back part.
// Depends on tbpf_pkg.
`default_nettype none
module tbpf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire tbpf_pkg::req_t req_i,
  output logic                busy_o,
  input  wire logic           pop_i,
  output logic                avail_o,
  output tbpf_pkg::job_t      job_o
);
  tbpf_pkg::job_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic push;

  assign busy_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = q_q[0];
  assign push    = start_i && !busy_o && (req_i.kind != tbpf_pkg::KindUnused);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(pop_i && avail_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i && avail_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i && avail_o) begin
      q_q[0] <= q_q[1];
      if (push) begin
        if (cnt_q == 2'd1) q_q[0] <= req_i;
        else q_q[1] <= req_i;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) q_q[0] <= req_i;
      else q_q[1] <= req_i;
    end
  end
endmodule
`default_nettype wire

/* rtl/tbpf_back.sv */
// Back part: memory writes and the multi-step pixel lookup sequencer.
// Depends on tbpf_pkg.
`default_nettype none
module tbpf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           avail_i,
  input  wire tbpf_pkg::job_t job_i,
  output logic                pop_o,
  input  wire logic [15:0]    ctrl_i,
  input  wire logic [2:0]     mode_i,
  input  wire logic           page_i,
  output logic                valid_o,
  output tbpf_pkg::res_t      res_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSe   = 3'd1;
  localparam logic [2:0] StSeW  = 3'd2;
  localparam logic [2:0] StPix  = 3'd3;
  localparam logic [2:0] StPixW = 3'd4;
  localparam logic [2:0] StPal  = 3'd5;
  localparam logic [2:0] StPalW = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [15:0] vram [tbpf_pkg::VideoHalfwords];
  logic [15:0] pal  [tbpf_pkg::PaletteEntries];
  logic [15:0] vdata_q, pdata_q;

  logic [2:0]  st_q, st_d;
  logic [16:0] vaddr_q, vaddr_d;
  logic        vbyte_q, vbyte_d;
  logic [9:0]  paddr_q, paddr_d;
  logic [14:0] col_q, col_d;
  logic        op_q, op_d;
  logic        zero_q, zero_d;
  logic [7:0]  se_lo_q, se_lo_d;
  logic [15:0] se_q, se_d;
  logic        pop;
  logic        vre, pre;

  logic [9:0]  x, y;
  logic [1:0]  sz;
  logic [16:0] cbase, sbase;
  logic        wide, tall;
  logic [2:0]  px, py;
  logic [7:0]  vb;
  logic [3:0]  nib;
  logic [16:0] a_tmp;
  logic [17:0] bmp_a;

  assign x = job_i.pixel_x;
  assign y = job_i.pixel_y;
  assign sz = ctrl_i[15:14];
  assign cbase = {1'b0, ctrl_i[3:2], 14'd0};
  assign sbase = {1'b0, ctrl_i[12:8], 11'd0};
  assign wide = sz[0];
  assign tall = sz[1];
  assign vb = vbyte_q ? vdata_q[15:8] : vdata_q[7:0];

  always_ff @(posedge clk_i) begin
    if (avail_i && st_q == StIdle && job_i.kind == tbpf_pkg::KindVram
        && {1'b0, job_i.mem_address} < 17'(tbpf_pkg::VideoHalfwords)) begin
      vram[job_i.mem_address] <= job_i.write_value;
    end
    if (vre) vdata_q <= vram[vaddr_q[15:0]];
  end

  always_ff @(posedge clk_i) begin
    if (avail_i && st_q == StIdle && job_i.kind == tbpf_pkg::KindPal
        && {1'b0, job_i.mem_address} < 17'(tbpf_pkg::PaletteEntries)) begin
      pal[job_i.mem_address[tbpf_pkg::PaddrW-1:0]] <= job_i.write_value;
    end
    if (pre) pdata_q <= pal[paddr_q[tbpf_pkg::PaddrW-1:0]];
  end

  assign vre = (st_q == StSe || st_q == StPix);
  assign pre = (st_q == StPal);
  assign pop_o = pop;

  always_comb begin
    st_d = st_q; vaddr_d = vaddr_q; vbyte_d = vbyte_q; paddr_d = paddr_q;
    col_d = col_q; op_d = op_q; zero_d = zero_q; se_lo_d = se_lo_q; se_d = se_q;
    pop = 1'b0;
    px = 3'd0; py = 3'd0; nib = 4'd0; a_tmp = 17'd0; bmp_a = 18'd0;
    valid_o = 1'b0;
    case (st_q)
      StIdle: begin
        if (avail_i) begin
          pop = 1'b1;
          if (job_i.kind == tbpf_pkg::KindQuery) begin
            zero_d = 1'b0; op_d = 1'b1; col_d = 15'd0; st_d = StOut;
            case (mode_i)
              tbpf_pkg::ModeText: begin
                if (x[9] || (x[8] && !wide) || y[9] || (y[8] && !tall)) begin
                  zero_d = 1'b1;
                end else begin
                  // Screenblock number: (ty>>5)*(w>>8)+(tx>>5).
                  a_tmp = 17'({2'd0, y[8]} * (wide ? 3'd2 : 3'd1) + {2'd0, x[8]})
                          << 10;
                  vaddr_d = (sbase >> 1) + a_tmp + {7'd0, y[7:3], x[7:3]};
                  vbyte_d = 1'b0;
                  st_d = StSe;
                end
              end
              tbpf_pkg::ModeAffine: begin
                if ((({7'd0, x} >> sz) >= 17'd128) || (({7'd0, y} >> sz) >= 17'd128)) begin
                  zero_d = 1'b1;
                end else begin
                  a_tmp = sbase + (17'(y[9:3]) << (3'd4 + 3'(sz))) + 17'(x[9:3]);
                  vaddr_d = {1'b0, a_tmp[16:1]};
                  vbyte_d = a_tmp[0];
                  st_d = StSe;
                end
              end
              tbpf_pkg::ModeBmp16: begin
                if (x >= 10'd240 || y >= 10'd160) begin
                  zero_d = 1'b1;
                end else begin
                  vaddr_d = 17'(x) + 17'(y) * 17'd240;
                  vbyte_d = 1'b0;
                  st_d = StPix;
                end
              end
              tbpf_pkg::ModeBmp8: begin
                if (x >= 10'd240 || y >= 10'd160) begin
                  zero_d = 1'b1;
                end else begin
                  bmp_a = (page_i ? 18'h0A000 : 18'd0) + 18'(x) + 18'(y) * 18'd240;
                  vaddr_d = bmp_a[17:1];
                  vbyte_d = bmp_a[0];
                  st_d = StPix;
                end
              end
              tbpf_pkg::ModeBmpSm: begin
                if (x >= 10'd160 || y >= 10'd128) begin
                  zero_d = 1'b1;
                end else begin
                  vaddr_d = (page_i ? 17'h05000 : 17'd0) + 17'(x) + 17'(y) * 17'd160;
                  vbyte_d = 1'b0;
                  st_d = StPix;
                end
              end
              default: zero_d = 1'b1;
            endcase
            se_lo_d = {x[2:0], y[2:0], 2'd0};
          end
        end
      end
      StSe: begin
        if (vaddr_q >= 17'(tbpf_pkg::VideoHalfwords)) begin
          zero_d = 1'b1; st_d = StOut;
        end else begin
          st_d = StSeW;
        end
      end
      StSeW: begin
        px = se_lo_q[7:5]; py = se_lo_q[4:2];
        if (mode_i == tbpf_pkg::ModeText) begin
          se_d = vdata_q;
          if (vdata_q[10]) px = 3'd7 - px;
          if (vdata_q[11]) py = 3'd7 - py;
          if (ctrl_i[7]) begin
            a_tmp = cbase + {1'b0, vdata_q[9:0], 6'd0} + {11'd0, py, px};
          end else begin
            a_tmp = cbase + {2'b0, vdata_q[9:0], 5'd0} + {12'd0, py, px[2:1]};
          end
          se_lo_d[0] = px[0];
        end else begin
          a_tmp = cbase + {3'd0, vb, 6'd0} + {11'd0, py, px};
        end
        vaddr_d = {1'b0, a_tmp[16:1]};
        vbyte_d = a_tmp[0];
        st_d = StPix;
      end
      StPix: begin
        if (vaddr_q >= 17'(tbpf_pkg::VideoHalfwords)) begin
          zero_d = 1'b1; st_d = StOut;
        end else begin
          st_d = StPixW;
        end
      end
      StPixW: begin
        nib = se_lo_q[0] ? vb[7:4] : vb[3:0];
        if (mode_i == tbpf_pkg::ModeBmp16 || mode_i == tbpf_pkg::ModeBmpSm) begin
          col_d = vdata_q[14:0]; op_d = 1'b1; st_d = StOut;
        end else if (mode_i == tbpf_pkg::ModeBmp8) begin
          paddr_d = {2'd0, vb}; op_d = 1'b1; st_d = StPal;
        end else if (mode_i == tbpf_pkg::ModeText && !ctrl_i[7]) begin
          paddr_d = {2'd0, se_q[15:12], nib};
          op_d = (nib != 4'd0); st_d = StPal;
        end else begin
          paddr_d = {2'd0, vb}; op_d = (vb != 8'd0); st_d = StPal;
        end
      end
      StPal: begin
        if (paddr_q >= 10'(tbpf_pkg::PaletteEntries)) begin
          col_d = 15'd0; st_d = StOut;
        end else begin
          st_d = StPalW;
        end
      end
      StPalW: begin
        col_d = pdata_q[14:0]; st_d = StOut;
      end
      StOut: begin
        valid_o = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    if (zero_q) begin
      res_o = '0;
    end else begin
      res_o.red    = {col_q[4:0], 3'd0};
      res_o.green  = {col_q[9:5], 3'd0};
      res_o.blue   = {col_q[14:10], 3'd0};
      res_o.opaque = op_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vaddr_q <= vaddr_d; vbyte_q <= vbyte_d; paddr_q <= paddr_d; col_q <= col_d;
    op_q <= op_d; zero_q <= zero_d; se_lo_q <= se_lo_d; se_q <= se_d;
  end
endmodule
`default_nettype wire

/* rtl/tiled_background_pixel_fetch.sv */
// Top level of the tiled background pixel fetch block.
// Depends on tbpf_pkg, tbpf_front and tbpf_back.
//
// A request is taken when start_i is high and busy_o is low. Kind 0 writes
// a halfword of video memory, kind 1 writes a palette entry, kind 2 asks for
// the colour of one layer pixel; kind 3 is dropped. Each query gives one
// result on result_o, marked by done_o for exactly one cycle; the receiver
// cannot stall. Writes give no result.
// Requests wait in a two-entry queue; a sequencer serves one at a time.
// A write is done as the idle sequencer takes it. A query outside the layer
// or with the mode off gives a zero result with no memory read; others pass
// the chain of screen entry (text, affine), pixel and palette (not in 16-bit
// bitmap modes) memory reads, which a read beyond memory ends early.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i
// while the block is idle; the user must keep to this, the block itself does
// not enforce it. Reset sets text mode and clears the queue; memory contents
// are undefined until written.
`default_nettype none
module tiled_background_pixel_fetch (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire tbpf_pkg::req_t request_i,
  output logic                busy_o,
  output logic                done_o,
  output tbpf_pkg::res_t      result_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [15:0]    cfg_data_i
);
  logic [15:0] ctrl_q;
  logic [2:0]  mode_q;
  logic        page_q;
  logic        avail, pop;
  tbpf_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= 16'd0;
      mode_q <= tbpf_pkg::ModeText;
      page_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tbpf_pkg::RegControl: ctrl_q <= cfg_data_i;
        tbpf_pkg::RegMode:    mode_q <= cfg_data_i[2:0];
        tbpf_pkg::RegPage:    page_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tbpf_front u_front (
    .clk_i, .rst_ni, .start_i, .req_i(request_i), .busy_o,
    .pop_i(pop), .avail_o(avail), .job_o(job)
  );

  tbpf_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .job_i(job), .pop_o(pop),
    .ctrl_i(ctrl_q), .mode_i(mode_q), .page_i(page_q),
    .valid_o(done_o), .res_o(result_o)
  );
endmodule
`default_nettype wire
